// ===== sv/pspu_pkg.sv =====
// Shared types, codes and constants of the packed scanline pixel unpacker.
package pspu_pkg;

    // Register indexes of the configuration port
    localparam logic [2:0] REG_UNIT_CODE      = 3'd0;
    localparam logic [2:0] REG_BYTE_ORDER_MSB = 3'd1;
    localparam logic [2:0] REG_BIT_ORDER_MSB  = 3'd2;
    localparam logic [2:0] REG_PIXEL_BITS     = 3'd3;
    localparam logic [2:0] REG_DEPTH_MODE     = 3'd4;
    localparam logic [2:0] REG_IMAGE_WIDTH    = 3'd5;
    localparam logic [2:0] REG_LINE_PIXELS    = 3'd6;
    localparam logic [2:0] REG_IMAGE_HEIGHT   = 3'd7;

    // Storage unit codes
    localparam logic [1:0] UNIT_8  = 2'd0;
    localparam logic [1:0] UNIT_16 = 2'd1;

    // Depth codes
    localparam logic [1:0] DEPTH_1  = 2'd0;
    localparam logic [1:0] DEPTH_8  = 2'd1;
    localparam logic [1:0] DEPTH_16 = 2'd2;

    // Geometry limits
    localparam logic [12:0] MAX_WIDTH  = 13'd4096;
    localparam logic [12:0] MAX_HEIGHT = 13'd4096;
    localparam logic [13:0] LINE_LIMIT = 14'd8192;

    // Unit queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam int CFG_DATA_W = 14;

    // Register set plus values derived from it
    typedef struct packed {
        logic [1:0]  unit_code;
        logic        byte_order_msb;
        logic        bit_order_msb;
        logic [1:0]  depth_mode;
        logic [5:0]  pix_bits;     // effective pixel width, 1..32
        logic [5:0]  pix_count;    // pixels per unit, 1..32
        logic [31:0] pix_mask;
        logic [4:0]  align_shift;  // moves a unit to the top of the word
        logic [12:0] vis_width;    // 1..MAX_WIDTH
        logic [13:0] line_len;     // vis_width..LINE_LIMIT
        logic [12:0] img_height;   // 1..MAX_HEIGHT
    } cfg_t;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    // Pixels that fit in a 32-bit unit for a given pixel width
    function automatic logic [5:0] pix_per_word(input logic [5:0] p);
        logic [5:0] n;
        begin
            case (p) inside
                6'd1:           n = 6'd32;
                6'd2:           n = 6'd16;
                6'd3:           n = 6'd10;
                6'd4:           n = 6'd8;
                6'd5:           n = 6'd6;
                6'd6:           n = 6'd5;
                [6'd7:6'd8]:    n = 6'd4;
                [6'd9:6'd10]:   n = 6'd3;
                [6'd11:6'd16]:  n = 6'd2;
                default:        n = 6'd1;
            endcase
            return n;
        end
    endfunction

endpackage

// ===== sv/pspu_cfg.sv =====
// Configuration registers and the geometry and pixel values derived from them.
module pspu_cfg
    import pspu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [2:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    logic [1:0]  unit_code_reg;
    logic        byte_order_msb_reg;
    logic        bit_order_msb_reg;
    logic [5:0]  pixel_bits_reg;
    logic [1:0]  depth_mode_reg;
    logic [12:0] image_width_reg;
    logic [13:0] line_pixels_reg;
    logic [12:0] image_height_reg;

    logic [5:0]  pix_bits_reg,    pix_bits_next;
    logic [5:0]  pix_count_reg,   pix_count_next;
    logic [31:0] pix_mask_reg,    pix_mask_next;
    logic [4:0]  align_shift_reg, align_shift_next;
    logic [12:0] vis_width_reg,   vis_width_next;
    logic [13:0] line_len_reg,    line_len_next;
    logic [12:0] img_height_reg,  img_height_next;

    logic [5:0]  unit_bits;
    logic [1:0]  count_shift;
    logic [13:0] line_clamped;

    // Write registers by index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_code_reg      <= UNIT_8;
            byte_order_msb_reg <= 1'b1;
            bit_order_msb_reg  <= 1'b1;
            pixel_bits_reg     <= 6'd8;
            depth_mode_reg     <= DEPTH_8;
            image_width_reg    <= 13'd1;
            line_pixels_reg    <= 14'd1;
            image_height_reg   <= 13'd1;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_UNIT_CODE:      unit_code_reg      <= cfg_data[1:0];
                REG_BYTE_ORDER_MSB: byte_order_msb_reg <= cfg_data[0];
                REG_BIT_ORDER_MSB:  bit_order_msb_reg  <= cfg_data[0];
                REG_PIXEL_BITS:     pixel_bits_reg     <= cfg_data[5:0];
                REG_DEPTH_MODE:     depth_mode_reg     <= cfg_data[1:0];
                REG_IMAGE_WIDTH:    image_width_reg    <= cfg_data[12:0];
                REG_LINE_PIXELS:    line_pixels_reg    <= cfg_data[13:0];
                REG_IMAGE_HEIGHT:   image_height_reg   <= cfg_data[12:0];
                default:            ;
            endcase
        end
    end

    // Derive unit size, pixel width, pixel count and clamped geometry
    always_comb
    begin
        case (unit_code_reg)
            UNIT_8:
            begin
                unit_bits        = 6'd8;
                count_shift      = 2'd2;
                align_shift_next = 5'd24;
            end
            UNIT_16:
            begin
                unit_bits        = 6'd16;
                count_shift      = 2'd1;
                align_shift_next = 5'd16;
            end
            default:
            begin
                unit_bits        = 6'd32;
                count_shift      = 2'd0;
                align_shift_next = 5'd0;
            end
        endcase

        if (pixel_bits_reg == 6'd0)
            pix_bits_next = 6'd1;
        else if (pixel_bits_reg > unit_bits)
            pix_bits_next = unit_bits;
        else
            pix_bits_next = pixel_bits_reg;

        pix_count_next = pix_per_word(pix_bits_next) >> count_shift;
        pix_mask_next  = (pix_bits_next == 6'd32) ? 32'hFFFF_FFFF
                                                  : ((32'd1 << pix_bits_next) - 32'd1);

        if (image_width_reg == 13'd0)
            vis_width_next = 13'd1;
        else if (image_width_reg > MAX_WIDTH)
            vis_width_next = MAX_WIDTH;
        else
            vis_width_next = image_width_reg;

        if (line_pixels_reg == 14'd0)
            line_clamped = 14'd1;
        else if (line_pixels_reg > LINE_LIMIT)
            line_clamped = LINE_LIMIT;
        else
            line_clamped = line_pixels_reg;
        line_len_next = (line_clamped < {1'b0, vis_width_next}) ? {1'b0, vis_width_next}
                                                                 : line_clamped;

        if (image_height_reg == 13'd0)
            img_height_next = 13'd1;
        else if (image_height_reg > MAX_HEIGHT)
            img_height_next = MAX_HEIGHT;
        else
            img_height_next = image_height_reg;
    end

    // Register the derived values; they follow the configuration registers in the next cycle
    always_ff @(posedge clk)
    begin
        pix_bits_reg    <= pix_bits_next;
        pix_count_reg   <= pix_count_next;
        pix_mask_reg    <= pix_mask_next;
        align_shift_reg <= align_shift_next;
        vis_width_reg   <= vis_width_next;
        line_len_reg    <= line_len_next;
        img_height_reg  <= img_height_next;
    end

    assign cfg.unit_code      = unit_code_reg;
    assign cfg.byte_order_msb = byte_order_msb_reg;
    assign cfg.bit_order_msb  = bit_order_msb_reg;
    assign cfg.depth_mode     = depth_mode_reg;
    assign cfg.pix_bits       = pix_bits_reg;
    assign cfg.pix_count      = pix_count_reg;
    assign cfg.pix_mask       = pix_mask_reg;
    assign cfg.align_shift    = align_shift_reg;
    assign cfg.vis_width      = vis_width_reg;
    assign cfg.line_len       = line_len_reg;
    assign cfg.img_height     = img_height_reg;

endmodule

// ===== sv/pspu_front.sv =====
// Front end: accepts bytes and gathers them into complete storage units.
module pspu_front
    import pspu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  queue_stat_t qstat,
    output logic        push,
    output logic [31:0] unit_word
);

    logic [31:0] shift_reg, shift_next;
    logic [1:0]  count_reg, count_next;

    logic        accept;
    logic [31:0] shift_upd;
    logic [1:0]  count_upd;
    logic [2:0]  unit_bytes;
    logic        complete;

    assign in_stall = qstat.full;
    assign accept   = in_valid && !in_stall;

    // Merge the byte and check for a complete unit
    always_comb
    begin
        case (cfg.unit_code)
            UNIT_8:  unit_bytes = 3'd1;
            UNIT_16: unit_bytes = 3'd2;
            default: unit_bytes = 3'd4;
        endcase

        if (cfg.byte_order_msb)
            shift_upd = {shift_reg[23:0], data_byte};
        else
            shift_upd = shift_reg | ({24'd0, data_byte} << {count_reg, 3'b000});

        count_upd = count_reg + 2'd1;
        complete  = (count_upd == 2'd0) || ({1'b0, count_upd} >= unit_bytes);

        case (cfg.unit_code)
            UNIT_8:  unit_word = {24'd0, shift_upd[7:0]};
            UNIT_16: unit_word = {16'd0, shift_upd[15:0]};
            default: unit_word = shift_upd;
        endcase

        push       = accept && complete;
        shift_next = shift_reg;
        count_next = count_reg;
        if (accept)
        begin
            shift_next = complete ? 32'd0 : shift_upd;
            count_next = complete ? 2'd0 : count_upd;
        end
    end

    // Advance the partial unit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= 32'd0;
            count_reg <= 2'd0;
        end
        else
        begin
            shift_reg <= shift_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== sv/pspu_queue.sv =====
// Short queue of complete units between front and back.
module pspu_queue
    import pspu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic [31:0] push_data,
    input  logic        pop,
    output logic [31:0] pop_data,
    output queue_stat_t qstat
);

    logic [31:0]         entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   fill_reg,   fill_next;

    assign qstat.full  = (fill_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign qstat.empty = (fill_reg == '0);
    assign pop_data    = entry_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
            fill_next = fill_reg + (QUEUE_AW+1)'(1);
        else if (pop && !push)
            fill_next = fill_reg - (QUEUE_AW+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store the pushed word
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== sv/pspu_back.sv =====
// Back end: cuts units into pixels, tracks line position, drops pad, splits color.
module pspu_back
    import pspu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  queue_stat_t qstat,
    input  logic [31:0] unit_word,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] pixel_raw,
    output logic [7:0]  color_index,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic        row_end,
    output logic        image_end,
    output logic        run_last
);

    logic        busy_reg,  busy_next;
    logic [31:0] word_reg,  word_next;
    logic [4:0]  k_reg,     k_next;
    logic [12:0] col_reg,   col_next;
    logic [11:0] row_reg,   row_next;

    logic        out_valid_reg, out_valid_next;
    logic [31:0] pixel_raw_reg;
    logic [7:0]  color_index_reg, red_reg, green_reg, blue_reg;
    logic        row_end_reg, image_end_reg, run_last_reg;

    logic        can_out, step, last_pix, load;
    logic [31:0] pix;
    logic [5:0]  remain;
    logic [13:0] col_inc;
    logic        wrap;
    logic [12:0] col_after;
    logic [13:0] pad_left;
    logic        visible, rend, last_row, later_visible;
    logic [7:0]  ci, r, g, b;

    assign can_out  = !out_valid_reg || !out_stall;
    assign step     = busy_reg && can_out;
    assign last_pix = ({1'b0, k_reg} == cfg.pix_count - 6'd1);
    assign load     = !qstat.empty && (!busy_reg || (step && last_pix));
    assign pop      = load;

    // Extract the current pixel and find where the line stands
    always_comb
    begin
        if (cfg.bit_order_msb)
            pix = word_reg >> (6'd32 - cfg.pix_bits);
        else
            pix = word_reg & cfg.pix_mask;

        col_inc   = {1'b0, col_reg} + 14'd1;
        wrap      = (col_inc >= cfg.line_len);
        col_after = wrap ? 13'd0 : col_inc[12:0];
        visible   = (col_reg < cfg.vis_width);
        rend      = (col_reg == cfg.vis_width - 13'd1);
        last_row  = (({1'b0, row_reg} + 13'd1) >= cfg.img_height);

        // Another visible pixel follows in this unit if the next column is
        // visible, or enough pixels remain to run through the pad and wrap
        remain        = cfg.pix_count - 6'd1 - {1'b0, k_reg};
        pad_left      = cfg.line_len - {1'b0, col_after};
        later_visible = (remain != 6'd0)
                        && ((col_after < cfg.vis_width) || ({8'd0, remain} > pad_left));
    end

    // Split the pixel by depth
    always_comb
    begin
        ci = 8'd0;
        r  = 8'd0;
        g  = 8'd0;
        b  = 8'd0;
        case (cfg.depth_mode)
            DEPTH_1:  ci = {7'd0, (pix != 32'd0)};
            DEPTH_8:  ci = pix[7:0];
            DEPTH_16:
            begin
                r = {3'd0, pix[15:11]};
                g = {2'd0, pix[10:5]};
                b = {3'd0, pix[4:0]};
            end
            default:
            begin
                r = pix[31:24];
                g = pix[23:16];
                b = pix[15:8];
            end
        endcase
    end

    // Advance the unit, pixel index and line position
    always_comb
    begin
        busy_next = busy_reg;
        word_next = word_reg;
        k_next    = k_reg;
        col_next  = col_reg;
        row_next  = row_reg;

        if (step)
        begin
            word_next = cfg.bit_order_msb ? (word_reg << cfg.pix_bits)
                                          : (word_reg >> cfg.pix_bits);
            k_next    = k_reg + 5'd1;
            col_next  = col_after;
            if (wrap)
                row_next = last_row ? 12'd0 : row_reg + 12'd1;
            if (last_pix)
                busy_next = 1'b0;
        end

        if (load)
        begin
            busy_next = 1'b1;
            k_next    = 5'd0;
            word_next = cfg.bit_order_msb ? (unit_word << cfg.align_shift) : unit_word;
        end

        if (step && visible)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            k_reg         <= 5'd0;
            col_reg       <= 13'd0;
            row_reg       <= 12'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            k_reg         <= k_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    // Load the output word on each visible pixel
    always_ff @(posedge clk)
    begin
        if (step && visible)
        begin
            pixel_raw_reg   <= pix;
            color_index_reg <= ci;
            red_reg         <= r;
            green_reg       <= g;
            blue_reg        <= b;
            row_end_reg     <= rend;
            image_end_reg   <= rend && last_row;
            run_last_reg    <= !later_visible;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_raw   = pixel_raw_reg;
    assign color_index = color_index_reg;
    assign red         = red_reg;
    assign green       = green_reg;
    assign blue        = blue_reg;
    assign row_end     = row_end_reg;
    assign image_end   = image_end_reg;
    assign run_last    = run_last_reg;

endmodule

// ===== sv/packed_scanline_pixel_unpacker.sv =====
// Packed scanline pixel unpacker: top level.
//
// Input channel: one raw image byte per word (in_valid, in_stall, data_byte), in file
// order. Bytes are gathered into 8, 16 or 32 bit units per unit_code and byte order.
// Output channel: one word per visible pixel (out_valid, out_stall, pixel fields), with
// row_end, image_end and run_last flags. Pad pixels at the end of a stored line give
// no word; a byte that completes no unit, or whose pixels are all pad, gives none.
// Configuration: write cfg_data to register cfg_index while cfg_write_en is high; only
// while no word is in flight.
// Path of a completed unit: queue entry, back end's unit register, output word register.
// Throughput: the back end steps through one pixel per cycle, pad pixels included,
// while the output is not stalled; bytes are accepted one per cycle while the
// four-unit queue has room.
// Reset returns the registers to their defaults, clears the partial unit, the queue
// and the row and column position, and drops any pending output word.
// A stalled receiver holds the output word; the back end then waits, the queue fills
// and in_stall rises once the queue is full.
module packed_scanline_pixel_unpacker
    import pspu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [2:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            data_byte,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [31:0]           pixel_raw,
    output logic [7:0]            color_index,
    output logic [7:0]            red,
    output logic [7:0]            green,
    output logic [7:0]            blue,
    output logic                  row_end,
    output logic                  image_end,
    output logic                  run_last
);

    cfg_t        cfg;
    queue_stat_t qstat;
    logic        push;
    logic        pop;
    logic [31:0] push_word;
    logic [31:0] pop_word;

    pspu_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    pspu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .qstat     (qstat),
        .push      (push),
        .unit_word (push_word)
    );

    pspu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_word),
        .pop       (pop),
        .pop_data  (pop_word),
        .qstat     (qstat)
    );

    pspu_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .qstat       (qstat),
        .unit_word   (pop_word),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_raw   (pixel_raw),
        .color_index (color_index),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .row_end     (row_end),
        .image_end   (image_end),
        .run_last    (run_last)
    );

endmodule

// ===== sv/pspu_checker.sv =====
// Port-level checks on the packed scanline pixel unpacker, bound to the top level.
module pspu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] pixel_raw,
    input logic [7:0]  color_index,
    input logic [7:0]  red,
    input logic [7:0]  green,
    input logic [7:0]  blue,
    input logic        row_end,
    input logic        image_end
);

    // A stalled pixel word stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pixel_raw) && $stable(row_end))
        else $error("stalled output word changed");

    // No output word while reset is held
    assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("output valid during reset");

    // The last pixel of the image also ends its row
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && image_end |-> row_end)
        else $error("image end without row end");

    // A zero pixel splits into zero components at every depth
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (pixel_raw == 32'd0)
        |-> (color_index == 8'd0) && (red == 8'd0) && (green == 8'd0) && (blue == 8'd0))
        else $error("nonzero color split of a zero pixel");

endmodule

bind packed_scanline_pixel_unpacker pspu_checker u_pspu_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_raw   (pixel_raw),
    .color_index (color_index),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .row_end     (row_end),
    .image_end   (image_end)
);
